// ===== hw/rtl/cle_pkg.sv =====
// Shared constants, codes and value conversion helpers for the circular list engine.
package cle_pkg;

    // Store geometry.
    localparam int CAPACITY    = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Operation codes.
    localparam logic [2:0] OP_INS_HEAD = 3'd0;
    localparam logic [2:0] OP_INS_TAIL = 3'd1;
    localparam logic [2:0] OP_INS_POS  = 3'd2;
    localparam logic [2:0] OP_DEL_POS  = 3'd3;
    localparam logic [2:0] OP_DUMP     = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Kind of the operation in flight.
    localparam logic [1:0] K_HEAD = 2'd0;
    localparam logic [1:0] K_TAIL = 2'd1;
    localparam logic [1:0] K_MID  = 2'd2;
    localparam logic [1:0] K_DEL  = 2'd3;

    // Low DATA_WIDTH bits of the sign-extended 32-bit input word.
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [31:0] v);
        logic [DATA_WIDTH-1:0] s;
        for (int i = 0; i < DATA_WIDTH; i++)
        begin
            s[i] = (i < 32) ? v[i] : v[31];
        end
        return s;
    endfunction

    // Stored word sign-extended (or cut) back to the 32-bit element field.
    function automatic logic signed [31:0] to_element(input logic [DATA_WIDTH-1:0] s);
        logic signed [31:0] e;
        for (int i = 0; i < 32; i++)
        begin
            e[i] = (i < DATA_WIDTH) ? s[i] : s[DATA_WIDTH-1];
        end
        return e;
    endfunction

endpackage

// ===== hw/rtl/cle_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/circular_list_engine_core.sv =====
// Circular singly linked list engine: node store, free chain and operation sequencer.
//
// Usage: drive operation, value and position and raise start; the item is taken at a
// rising edge where start is high and busy is low. Results come back on element,
// status, length and last, each valid for exactly one cycle while done is high.
// Insert and delete give one status beat; a dump gives one beat per node from the
// head (at most 32), with last set on the final one; an empty dump gives one beat
// with the empty status. The receiver cannot stall, so results are never held.
// Rejected items, single-node deletes and unused codes give their beat in the cycle
// after acceptance. Head and tail inserts pass through S_FREE_RD and, unless the list
// was empty, S_LINK_W; a head delete through S_DEL_HEAD and S_FREE_W. An insert inside
// the list passes S_FREE_RD, the link walk and S_LINK_W, a delete behind the head the
// walk, S_DEL_CUR and S_FREE_W; the walk reads one link from the link memory per cycle.
// A dump reads both memories once per node, one node per cycle.
// The block is busy for the whole operation and takes the next item once busy drops.
// Reset empties the list, puts every node on the free chain through per-entry link
// valid bits, and clears the sequencer; the value memory needs no clearing.
module circular_list_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic               done,
    output logic signed [31:0] element,
    output logic [1:0]         status,
    output logic [5:0]         length,
    output logic               last
);

    localparam int IDX_W = cle_pkg::IDX_W;
    localparam int CNT_W = cle_pkg::CNT_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FREE_RD  = 3'd1;
    localparam logic [2:0] S_WALK     = 3'd2;
    localparam logic [2:0] S_LINK_W   = 3'd3;
    localparam logic [2:0] S_DEL_HEAD = 3'd4;
    localparam logic [2:0] S_DEL_CUR  = 3'd5;
    localparam logic [2:0] S_FREE_W   = 3'd6;
    localparam logic [2:0] S_DUMP     = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       kind_reg, kind_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] steps_reg, steps_next;
    logic [IDX_W-1:0] node_reg, node_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             link_valid_reg [cle_pkg::CAPACITY];

    logic               done_reg, done_next;
    logic signed [31:0] element_reg, element_next;
    logic [1:0]         status_reg, status_next;
    logic [5:0]         length_reg, length_next;
    logic               last_reg, last_next;

    // Memory ports.
    logic                            lk_we, lk_re;
    logic [IDX_W-1:0]                lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic                            vl_we;
    logic [IDX_W-1:0]                vl_waddr, vl_raddr;
    logic [cle_pkg::DATA_WIDTH-1:0]  vl_wdata, vl_rdata;

    logic [IDX_W-1:0] link_rd;
    logic [IDX_W-1:0] rd_succ;

    cle_ram #(
        .WIDTH (IDX_W),
        .DEPTH (cle_pkg::CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    cle_ram #(
        .WIDTH (cle_pkg::DATA_WIDTH),
        .DEPTH (cle_pkg::CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (vl_we),
        .waddr (vl_waddr),
        .wdata (vl_wdata),
        .raddr (vl_raddr),
        .rdata (vl_rdata)
    );

    // A link never written since reset still holds its free-chain successor.
    assign rd_succ = (rd_addr_reg == IDX_W'(cle_pkg::CAPACITY - 1)) ? '0
                                                                      : rd_addr_reg + IDX_W'(1);
    assign link_rd = link_valid_reg[rd_addr_reg] ? lk_rdata : rd_succ;

    // Sequencer next-state and memory control.
    always_comb
    begin
        logic             emit;
        logic [1:0]       emit_status;
        logic             emit_last;
        logic signed [31:0] emit_elem;

        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        ptr_next    = ptr_reg;
        steps_next  = steps_reg;
        node_next   = node_reg;
        remain_next = remain_reg;

        lk_we    = 1'b0;
        lk_re    = 1'b0;
        lk_waddr = node_reg;
        lk_wdata = '0;
        lk_raddr = '0;
        vl_we    = 1'b0;
        vl_waddr = free_reg;
        vl_wdata = cle_pkg::to_store(value);
        vl_raddr = '0;

        emit        = 1'b0;
        emit_status = cle_pkg::ST_OK;
        emit_last   = 1'b1;
        emit_elem   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (operation) inside
                        cle_pkg::OP_INS_HEAD, cle_pkg::OP_INS_TAIL, cle_pkg::OP_INS_POS:
                        begin
                            if (operation == cle_pkg::OP_INS_POS && position == 8'd0)
                            begin
                                emit        = 1'b1;
                                emit_status = cle_pkg::ST_RANGE;
                            end
                            else if (count_reg >= CNT_W'(cle_pkg::CAPACITY))
                            begin
                                emit        = 1'b1;
                                emit_status = cle_pkg::ST_FULL;
                            end
                            else
                            begin
                                // Claim the free head: store the value, fetch its successor.
                                node_next  = free_reg;
                                vl_we      = 1'b1;
                                lk_re      = 1'b1;
                                lk_raddr   = free_reg;
                                steps_next = IDX_W'(position - 8'd2);
                                state_next = S_FREE_RD;
                                if (operation == cle_pkg::OP_INS_HEAD ||
                                    (operation == cle_pkg::OP_INS_POS && position == 8'd1))
                                begin
                                    kind_next = cle_pkg::K_HEAD;
                                end
                                else if (operation == cle_pkg::OP_INS_TAIL ||
                                         position > 8'(count_reg))
                                begin
                                    kind_next = cle_pkg::K_TAIL;
                                end
                                else
                                begin
                                    kind_next = cle_pkg::K_MID;
                                end
                            end
                        end
                        cle_pkg::OP_DEL_POS:
                        begin
                            if (count_reg == '0)
                            begin
                                emit        = 1'b1;
                                emit_status = cle_pkg::ST_EMPTY;
                            end
                            else if (position == 8'd0 || position > 8'(count_reg))
                            begin
                                emit        = 1'b1;
                                emit_status = cle_pkg::ST_RANGE;
                            end
                            else if (count_reg == CNT_W'(1))
                            begin
                                // The only node goes back to the free chain.
                                lk_we      = 1'b1;
                                lk_waddr   = head_reg;
                                lk_wdata   = free_reg;
                                free_next  = head_reg;
                                head_next  = '0;
                                tail_next  = '0;
                                count_next = '0;
                                emit       = 1'b1;
                            end
                            else if (position == 8'd1)
                            begin
                                lk_re      = 1'b1;
                                lk_raddr   = head_reg;
                                node_next  = head_reg;
                                state_next = S_DEL_HEAD;
                            end
                            else
                            begin
                                lk_re      = 1'b1;
                                lk_raddr   = head_reg;
                                ptr_next   = head_reg;
                                steps_next = IDX_W'(position - 8'd2);
                                kind_next  = cle_pkg::K_DEL;
                                state_next = S_WALK;
                            end
                        end
                        cle_pkg::OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit        = 1'b1;
                                emit_status = cle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                lk_re       = 1'b1;
                                lk_raddr    = head_reg;
                                vl_raddr    = head_reg;
                                remain_next = (8'(count_reg) > 8'(cle_pkg::MAX_RESULTS))
                                              ? CNT_W'(cle_pkg::MAX_RESULTS) : count_reg;
                                state_next  = S_DUMP;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_FREE_RD:
            begin
                free_next = link_rd;
                if (kind_reg == cle_pkg::K_MID)
                begin
                    lk_re      = 1'b1;
                    lk_raddr   = head_reg;
                    ptr_next   = head_reg;
                    state_next = S_WALK;
                end
                else
                begin
                    lk_we    = 1'b1;
                    lk_waddr = node_reg;
                    lk_wdata = (count_reg == '0) ? node_reg : head_reg;
                    if (count_reg == '0)
                    begin
                        head_next  = node_reg;
                        tail_next  = node_reg;
                        count_next = count_reg + CNT_W'(1);
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LINK_W;
                    end
                end
            end
            S_WALK:
            begin
                // One link per cycle; the read data of the last step is link(prev).
                if (steps_reg == '0)
                begin
                    if (kind_reg == cle_pkg::K_DEL)
                    begin
                        node_next  = link_rd;
                        lk_re      = 1'b1;
                        lk_raddr   = link_rd;
                        state_next = S_DEL_CUR;
                    end
                    else
                    begin
                        lk_we      = 1'b1;
                        lk_waddr   = node_reg;
                        lk_wdata   = link_rd;
                        state_next = S_LINK_W;
                    end
                end
                else
                begin
                    ptr_next   = link_rd;
                    steps_next = steps_reg - IDX_W'(1);
                    lk_re      = 1'b1;
                    lk_raddr   = link_rd;
                end
            end
            S_LINK_W:
            begin
                // Hook the new node in behind the tail or behind prev.
                lk_we      = 1'b1;
                lk_waddr   = (kind_reg == cle_pkg::K_MID) ? ptr_reg : tail_reg;
                lk_wdata   = node_reg;
                count_next = count_reg + CNT_W'(1);
                if (kind_reg == cle_pkg::K_HEAD)
                begin
                    head_next = node_reg;
                end
                if (kind_reg == cle_pkg::K_TAIL)
                begin
                    tail_next = node_reg;
                end
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_DEL_HEAD:
            begin
                head_next  = link_rd;
                lk_we      = 1'b1;
                lk_waddr   = tail_reg;
                lk_wdata   = link_rd;
                state_next = S_FREE_W;
            end
            S_DEL_CUR:
            begin
                lk_we    = 1'b1;
                lk_waddr = ptr_reg;
                lk_wdata = link_rd;
                if (node_reg == tail_reg)
                begin
                    tail_next = ptr_reg;
                end
                state_next = S_FREE_W;
            end
            S_FREE_W:
            begin
                lk_we      = 1'b1;
                lk_waddr   = node_reg;
                lk_wdata   = free_reg;
                free_next  = node_reg;
                count_next = count_reg - CNT_W'(1);
                emit       = 1'b1;
                state_next = S_IDLE;
            end
            S_DUMP:
            begin
                // One node per cycle: value and link of the node read last cycle.
                emit        = 1'b1;
                emit_elem   = cle_pkg::to_element(vl_rdata);
                emit_last   = (remain_reg == CNT_W'(1));
                lk_re       = 1'b1;
                lk_raddr    = link_rd;
                vl_raddr    = link_rd;
                remain_next = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        done_next    = emit;
        element_next = emit_elem;
        status_next  = emit_status;
        last_next    = emit_last;
        length_next  = 6'(count_next);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= '0;
            count_reg  <= '0;
            kind_reg   <= cle_pkg::K_HEAD;
            steps_reg  <= '0;
            remain_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
            count_reg  <= count_next;
            kind_reg   <= kind_next;
            steps_reg  <= steps_next;
            remain_reg <= remain_next;
            done_reg   <= done_next;
        end
    end

    // Link valid bits: set on the first write of each entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cle_pkg::CAPACITY; i++)
            begin
                link_valid_reg[i] <= 1'b0;
            end
        end
        else if (lk_we)
        begin
            link_valid_reg[lk_waddr] <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        node_reg    <= node_next;
        rd_addr_reg <= lk_raddr;
        element_reg <= element_next;
        status_reg  <= status_next;
        length_reg  <= length_next;
        last_reg    <= last_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign element = element_reg;
    assign status  = status_reg;
    assign length  = length_reg;
    assign last    = last_reg;

`ifndef ASSERT_OFF
    // The link memory is never read and written in the same cycle.
    a_no_link_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(lk_we && lk_re))
        else $error("link memory read and written in the same cycle");

    // Only a dump gives beats that are not the final one.
    a_mid_beat_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |-> (state_reg == S_DUMP))
        else $error("non-final beat outside a dump");

    // A dump of a non-empty list keeps the block busy.
    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == cle_pkg::OP_DUMP && count_reg != '0) |=> busy)
        else $error("dump of a non-empty list did not start");

    // The node count stays within the store.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(cle_pkg::CAPACITY))
        else $error("node count above capacity");
`endif

endmodule
